[hdl/pll_nk_factor_search_core_macros.svh]
// Assertion helpers shared by pnk_search and pll_nk_factor_search_core.
`ifndef PLL_NK_FACTOR_SEARCH_CORE_MACROS_SVH
`define PLL_NK_FACTOR_SEARCH_CORE_MACROS_SVH

`ifndef SYNTH
`define PNK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PNK_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define PNK_ASSERT(lbl, prop, msg)
`define PNK_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

[hdl/pnk_pkg.sv]
package pnk_pkg;

  localparam int unsigned RATE_W  = 32;
  localparam int unsigned N_W     = 6;
  localparam int unsigned K_W     = 3;
  localparam int unsigned DIV_W   = 8;
  localparam int unsigned SCALE_W = RATE_W + DIV_W;      // target * post divider
  localparam int unsigned BASE_W  = RATE_W + K_W;        // parent * k
  localparam int unsigned PROD_W  = RATE_W + K_W + N_W;  // parent * k * n

  typedef logic [N_W-1:0]     n_t;
  typedef logic [K_W-1:0]     k_t;
  typedef logic [RATE_W-1:0]  rate_t;
  typedef logic [DIV_W-1:0]   div_t;
  typedef logic [SCALE_W-1:0] scale_t;
  typedef logic [BASE_W-1:0]  base_t;
  typedef logic [PROD_W-1:0]  prod_t;

  typedef enum logic [2:0] {
    CFG_MIN_N       = 3'd0,
    CFG_MAX_N       = 3'd1,
    CFG_MIN_K       = 3'd2,
    CFG_MAX_K       = 3'd3,
    CFG_POST_DIV_EN = 3'd4,
    CFG_POST_DIV    = 3'd5,
    CFG_N_OFFSET    = 3'd6,
    CFG_K_OFFSET    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    n_t   min_n;
    n_t   max_n;
    k_t   min_k;
    k_t   max_k;
    logic post_div_en;
    div_t post_div;
    logic n_offset;
    logic k_offset;
  } cfg_t;

  typedef struct packed {
    logic  found;
    n_t    best_n;
    k_t    best_k;
    prod_t best_prod;
  } srch_res_t;

endpackage

[hdl/pnk_search.sv]
module pnk_search #(
  parameter int unsigned N_WIDTH = 5,
  parameter int unsigned K_WIDTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  pnk_pkg::rate_t      parent_i,
  input  pnk_pkg::rate_t      target_i,
  input  pnk_pkg::div_t       div_i,
  input  pnk_pkg::cfg_t       cfg_i,
  output logic                done_o,
  output pnk_pkg::srch_res_t  res_o
);

  localparam int unsigned NCAP = 1 << N_WIDTH;
  localparam int unsigned KCAP = 1 << K_WIDTH;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_BASE = 5'b00010,
    S_PROD = 5'b00100,
    S_TRY  = 5'b01000,
    S_FIN  = 5'b10000
  } srch_state_e;

  srch_state_e      state_q, state_d;
  pnk_pkg::rate_t   parent_q;
  pnk_pkg::scale_t  target_q;
  pnk_pkg::base_t   base_q;
  pnk_pkg::prod_t   prod_q, best_q;
  pnk_pkg::n_t      n_q, best_n_q;
  pnk_pkg::k_t      k_q, best_k_q;
  logic             valid_q;

  pnk_pkg::n_t      lo_n, hi_n;
  pnk_pkg::k_t      lo_k, hi_k;
  logic             empty;
  logic             fits, better;

  // effective bounds: zero minimum acts as one, maximum limited to the code field
  assign lo_n  = (cfg_i.min_n == '0) ? pnk_pkg::n_t'(1) : cfg_i.min_n;
  assign lo_k  = (cfg_i.min_k == '0) ? pnk_pkg::k_t'(1) : cfg_i.min_k;
  assign hi_n  = (32'(cfg_i.max_n) > NCAP) ? pnk_pkg::n_t'(NCAP) : cfg_i.max_n;
  assign hi_k  = (32'(cfg_i.max_k) > KCAP) ? pnk_pkg::k_t'(KCAP) : cfg_i.max_k;
  assign empty = (lo_n > hi_n) || (lo_k > hi_k);

  // with both values at or below target, closer means larger; ties keep the first
  assign fits   = prod_q <= pnk_pkg::prod_t'(target_q);
  assign better = fits && (!valid_q || (prod_q > best_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start_i) state_d = empty ? S_FIN : S_BASE;
      S_BASE: state_d = S_PROD;
      S_PROD: state_d = S_TRY;
      S_TRY: begin
        if (n_q == hi_n) begin
          state_d = (k_q == hi_k) ? S_FIN : S_BASE;
        end
      end
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && start_i) begin
        valid_q <= 1'b0;
      end else if (state_q == S_TRY && better) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          parent_q <= parent_i;
          target_q <= pnk_pkg::scale_t'(target_i) * pnk_pkg::scale_t'(div_i);
          n_q      <= lo_n;
          k_q      <= lo_k;
        end
      end
      S_BASE: base_q <= pnk_pkg::base_t'(parent_q) * pnk_pkg::base_t'(k_q);
      S_PROD: prod_q <= pnk_pkg::prod_t'(base_q) * pnk_pkg::prod_t'(n_q);
      S_TRY: begin
        if (better) begin
          best_q   <= prod_q;
          best_n_q <= n_q;
          best_k_q <= k_q;
        end
        if (n_q == hi_n) begin
          n_q <= lo_n;
          k_q <= k_q + pnk_pkg::k_t'(1);
        end else begin
          n_q    <= n_q + pnk_pkg::n_t'(1);
          prod_q <= prod_q + pnk_pkg::prod_t'(base_q);
        end
      end
      default: ;
    endcase
  end

  assign done_o          = (state_q == S_FIN);
  assign res_o.found     = valid_q;
  assign res_o.best_n    = best_n_q;
  assign res_o.best_k    = best_k_q;
  assign res_o.best_prod = best_q;

`include "pll_nk_factor_search_core_macros.svh"

  `PNK_ASSERT(a_try_in_bounds, (state_q == S_TRY) |-> (n_q >= lo_n && n_q <= hi_n && k_q >= lo_k && k_q <= hi_k), "trial outside the search bounds")
  `PNK_ASSERT(a_best_fits, (valid_q && state_q == S_TRY) |-> (best_q <= pnk_pkg::prod_t'(target_q)), "kept product exceeds target")

endmodule

[hdl/pnk_div.sv]
module pnk_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  pnk_pkg::prod_t  dividend_i,
  input  pnk_pkg::div_t   divisor_i,
  output logic            done_o,
  output pnk_pkg::rate_t  quotient_o
);

  localparam int unsigned CNT_W = $clog2(pnk_pkg::PROD_W);

  logic                                busy_q, done_q;
  logic [CNT_W-1:0]                    cnt_q;
  pnk_pkg::prod_t                      acc_q;
  pnk_pkg::div_t                       rem_q, div_q;
  logic [pnk_pkg::DIV_W:0]             rem_sh, rem_sub;
  logic                                qbit;

  // restoring division, one quotient bit per cycle; acc shifts dividend out, quotient in
  assign rem_sh  = {rem_q, acc_q[pnk_pkg::PROD_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign qbit    = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(pnk_pkg::PROD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[pnk_pkg::PROD_W-2:0], qbit};
      rem_q <= qbit ? rem_sub[pnk_pkg::DIV_W-1:0] : rem_sh[pnk_pkg::DIV_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = acc_q[pnk_pkg::RATE_W-1:0];

endmodule

[hdl/pll_nk_factor_search_core.sv]
// PLL N*K multiplier factor search.
// A request (parent_rate_i, target_rate_i) is taken at a clock edge where start
// is high and busy is low. busy then stays high until the result is shown.
// The result fields are valid for the single cycle in which done_o is high;
// the receiver cannot hold them off, so a sink must take them in that cycle.
// Per K value the search runs a base step, a product step and one trial per N
// value in range; a closing step ends the search. Only when a pair fits does
// the bit-serial post division follow, one quotient bit per cycle over the full
// product width, before the done_o cycle; a miss goes from the closing step
// straight to done_o. The N*K trial loop over one add/compare unit and the
// bit-serial divider set how long a request takes. A new start is taken in the
// done_o cycle: one request at a time.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once
// and belong only in the idle time between requests.
// Reset clears busy and done_o and loads the default search bounds.
module pll_nk_factor_search_core #(
  parameter int unsigned N_WIDTH = 5,
  parameter int unsigned K_WIDTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  pnk_pkg::rate_t       parent_rate_i,
  input  pnk_pkg::rate_t       target_rate_i,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  output logic                 done_o,
  output pnk_pkg::n_t          best_n_o,
  output pnk_pkg::k_t          best_k_o,
  output logic [N_WIDTH-1:0]   n_code_o,
  output logic [K_WIDTH-1:0]   k_code_o,
  output pnk_pkg::rate_t       achieved_rate_o,
  output logic                 found_o
);

  localparam int unsigned NCW = (N_WIDTH > pnk_pkg::N_W) ? N_WIDTH : pnk_pkg::N_W;
  localparam int unsigned KCW = (K_WIDTH > pnk_pkg::K_W) ? K_WIDTH : pnk_pkg::K_W;

  pnk_pkg::cfg_t       cfg_q;
  logic                busy_q, done_q;
  logic                accept;
  pnk_pkg::div_t       div_eff;
  logic                srch_done;
  pnk_pkg::srch_res_t  srch_res;
  logic                div_start, div_done;
  pnk_pkg::rate_t      quotient;
  logic [NCW-1:0]      n_diff;
  logic [KCW-1:0]      k_diff;

  assign accept  = start && !busy_q;
  assign div_eff = !cfg_q.post_div_en ? pnk_pkg::div_t'(1) :
                   (cfg_q.post_div == '0) ? pnk_pkg::div_t'(1) : cfg_q.post_div;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_n       <= pnk_pkg::n_t'(1);
      cfg_q.max_n       <= pnk_pkg::n_t'(32);
      cfg_q.min_k       <= pnk_pkg::k_t'(1);
      cfg_q.max_k       <= pnk_pkg::k_t'(4);
      cfg_q.post_div_en <= 1'b0;
      cfg_q.post_div    <= pnk_pkg::div_t'(1);
      cfg_q.n_offset    <= 1'b1;
      cfg_q.k_offset    <= 1'b1;
    end else if (cfg_we_i) begin
      case (pnk_pkg::cfg_idx_e'(cfg_idx_i))
        pnk_pkg::CFG_MIN_N:       cfg_q.min_n       <= cfg_data_i[pnk_pkg::N_W-1:0];
        pnk_pkg::CFG_MAX_N:       cfg_q.max_n       <= cfg_data_i[pnk_pkg::N_W-1:0];
        pnk_pkg::CFG_MIN_K:       cfg_q.min_k       <= cfg_data_i[pnk_pkg::K_W-1:0];
        pnk_pkg::CFG_MAX_K:       cfg_q.max_k       <= cfg_data_i[pnk_pkg::K_W-1:0];
        pnk_pkg::CFG_POST_DIV_EN: cfg_q.post_div_en <= cfg_data_i[0];
        pnk_pkg::CFG_POST_DIV:    cfg_q.post_div    <= cfg_data_i;
        pnk_pkg::CFG_N_OFFSET:    cfg_q.n_offset    <= cfg_data_i[0];
        pnk_pkg::CFG_K_OFFSET:    cfg_q.k_offset    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  pnk_search #(
    .N_WIDTH (N_WIDTH),
    .K_WIDTH (K_WIDTH)
  ) u_search (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .parent_i (parent_rate_i),
    .target_i (target_rate_i),
    .div_i    (div_eff),
    .cfg_i    (cfg_q),
    .done_o   (srch_done),
    .res_o    (srch_res)
  );

  assign div_start = srch_done && srch_res.found;

  pnk_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (srch_res.best_prod),
    .divisor_i  (div_eff),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // codes wrap modulo the field size
  assign n_diff = NCW'(srch_res.best_n) - NCW'(cfg_q.n_offset);
  assign k_diff = KCW'(srch_res.best_k) - KCW'(cfg_q.k_offset);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (div_done || (srch_done && !srch_res.found)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      best_n_o        <= srch_res.best_n;
      best_k_o        <= srch_res.best_k;
      n_code_o        <= n_diff[N_WIDTH-1:0];
      k_code_o        <= k_diff[K_WIDTH-1:0];
      achieved_rate_o <= quotient;
      found_o         <= 1'b1;
    end else if (srch_done && !srch_res.found) begin
      best_n_o        <= '0;
      best_k_o        <= '0;
      n_code_o        <= '0;
      k_code_o        <= '0;
      achieved_rate_o <= '0;
      found_o         <= 1'b0;
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;

`include "pll_nk_factor_search_core_macros.svh"

  `PNK_ASSERT(a_done_after_busy, done_o |-> $past(busy_q), "result without a pending request")
  `PNK_ASSERT(a_miss_zero, (done_o && !found_o) |-> (best_n_o == '0 && best_k_o == '0 && achieved_rate_o == '0), "miss result not cleared")
  `PNK_ASSERT(a_hit_nonzero, (done_o && found_o) |-> (best_n_o != '0 && best_k_o != '0), "hit with a zero factor")
  `PNK_ASSERT_NEVER(a_no_overlap, srch_done && div_done, "search and division finished together")

endmodule

[verif/testbench.sv]
module testbench;

  localparam int unsigned NF_W = 5;
  localparam int unsigned KF_W = 2;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic            found;
    pnk_pkg::n_t     best_n;
    pnk_pkg::k_t     best_k;
    logic [NF_W-1:0] n_code;
    logic [KF_W-1:0] k_code;
    pnk_pkg::rate_t  rate;
  } nk_result_t;

  localparam pnk_pkg::cfg_t RESET_CFG = '{min_n: 6'd1, max_n: 6'd32, min_k: 3'd1,
                                          max_k: 3'd4, post_div_en: 1'b0, post_div: 8'd1,
                                          n_offset: 1'b1, k_offset: 1'b1};

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  pnk_pkg::rate_t  parent_rate_i;
  pnk_pkg::rate_t  target_rate_i;
  logic            cfg_we_i;
  logic [2:0]      cfg_idx_i;
  logic [7:0]      cfg_data_i;
  logic            done_o;
  pnk_pkg::n_t     best_n_o;
  pnk_pkg::k_t     best_k_o;
  logic [NF_W-1:0] n_code_o;
  logic [KF_W-1:0] k_code_o;
  pnk_pkg::rate_t  achieved_rate_o;
  logic            found_o;

  pnk_pkg::cfg_t model_cfg = RESET_CFG;
  nk_result_t    pending_results[$];
  nk_result_t    oldest;
  int            errors;
  int            item_count;
  int            result_count;
  int            found_count;
  int            config_count;
  int            idle_pct;
  longint        cycle_count;

  pll_nk_factor_search_core #(
    .N_WIDTH(NF_W),
    .K_WIDTH(KF_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .parent_rate_i  (parent_rate_i),
    .target_rate_i  (target_rate_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .best_n_o       (best_n_o),
    .best_k_o       (best_k_o),
    .n_code_o       (n_code_o),
    .k_code_o       (k_code_o),
    .achieved_rate_o(achieved_rate_o),
    .found_o        (found_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Closest parent*N*K not above the (scaled) target; K outer, N inner, first pair wins ties.
  function automatic nk_result_t search_nk(pnk_pkg::cfg_t c, pnk_pkg::rate_t parent,
                                           pnk_pkg::rate_t target);
    nk_result_t  r;
    logic [63:0] goal;
    logic [63:0] prod;
    logic [63:0] best;
    int unsigned div;
    int unsigned lo_n;
    int unsigned hi_n;
    int unsigned lo_k;
    int unsigned hi_k;
    r = '0;
    best = '0;
    div = 1;
    goal = 64'(target);
    if (c.post_div_en) begin
      div = (c.post_div == '0) ? 1 : int'(c.post_div);
      goal = goal * div;
    end
    lo_n = (c.min_n == '0) ? 1 : int'(c.min_n);
    hi_n = (c.max_n > (1 << NF_W)) ? (1 << NF_W) : int'(c.max_n);
    lo_k = (c.min_k == '0) ? 1 : int'(c.min_k);
    hi_k = (c.max_k > (1 << KF_W)) ? (1 << KF_W) : int'(c.max_k);
    for (int unsigned k = lo_k; k <= hi_k; k++) begin
      for (int unsigned n = lo_n; n <= hi_n; n++) begin
        prod = 64'(parent) * n * k;
        if (prod <= goal && (!r.found || prod > best)) begin
          r.found = 1'b1;
          best = prod;
          r.best_n = pnk_pkg::n_t'(n);
          r.best_k = pnk_pkg::k_t'(k);
        end
      end
    end
    if (r.found) begin
      r.n_code = NF_W'(r.best_n - c.n_offset);
      r.k_code = KF_W'(r.best_k - c.k_offset);
      r.rate = pnk_pkg::rate_t'(best / div);
    end
    return r;
  endfunction

  function automatic pnk_pkg::cfg_t random_cfg();
    pnk_pkg::cfg_t c;
    c.min_n = pnk_pkg::n_t'($urandom_range(0, 20));
    c.max_n = pnk_pkg::n_t'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) :
                                                           $urandom_range(c.min_n, 40));
    c.min_k = pnk_pkg::k_t'($urandom_range(0, 3));
    c.max_k = pnk_pkg::k_t'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) :
                                                           $urandom_range(c.min_k, 5));
    c.post_div_en = 1'($urandom_range(0, 1));
    c.post_div = pnk_pkg::div_t'($urandom);
    c.n_offset = 1'($urandom);
    c.k_offset = 1'($urandom);
    return c;
  endfunction

  // Writes every register; unused upper data bits carry noise.
  task automatic load_config(pnk_pkg::cfg_t c);
    pnk_pkg::cfg_idx_e idx;
    logic [7:0]        data;
    for (int i = 0; i < 8; i++) begin
      idx = pnk_pkg::cfg_idx_e'(i);
      data = 8'($urandom);
      case (idx)
        pnk_pkg::CFG_MIN_N:       data[5:0] = c.min_n;
        pnk_pkg::CFG_MAX_N:       data[5:0] = c.max_n;
        pnk_pkg::CFG_MIN_K:       data[2:0] = c.min_k;
        pnk_pkg::CFG_MAX_K:       data[2:0] = c.max_k;
        pnk_pkg::CFG_POST_DIV_EN: data[0]   = c.post_div_en;
        pnk_pkg::CFG_POST_DIV:    data      = c.post_div;
        pnk_pkg::CFG_N_OFFSET:    data[0]   = c.n_offset;
        pnk_pkg::CFG_K_OFFSET:    data[0]   = c.k_offset;
        default:                  data      = '0;
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= data;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    model_cfg = c;
    config_count++;
  endtask

  // Waits for the edge of the transfer; start stays high unless the sender idles.
  task automatic request_search(pnk_pkg::rate_t parent, pnk_pkg::rate_t target);
    start         <= 1'b1;
    parent_rate_i <= parent;
    target_rate_i <= target;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(search_nk(model_cfg, parent, target));
    item_count++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 220)) @(posedge clk_i);
    end
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Mostly targets near a multiple of the parent so the search lands on edges.
  task automatic pick_rates(output pnk_pkg::rate_t parent, output pnk_pkg::rate_t target);
    logic [63:0] goal;
    int unsigned div;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    parent = $urandom >> $urandom_range(0, 31);
    target = '0;
    if (sel == 0) begin
      parent = $urandom;
      target = $urandom;
    end else if (sel == 1) begin
      parent = '0;
      target = $urandom >> $urandom_range(0, 31);
    end else begin
      div = (model_cfg.post_div_en && model_cfg.post_div != '0) ?
            int'(model_cfg.post_div) : 1;
      goal = 64'(parent) * $urandom_range(0, 140);
      case ($urandom_range(0, 2))
        0:       goal = goal + $urandom_range(0, 3);
        1:       goal = goal + parent / 2;
        default: if (goal != 0) goal = goal - 1;
      endcase
      goal = goal / div;
      target = (goal > 64'hFFFF_FFFF) ? '1 : pnk_pkg::rate_t'(goal);
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none actual n=%0d k=%0d rate=%0d",
                 $time, best_n_o, best_k_o, achieved_rate_o);
      end else begin
        oldest = pending_results.pop_front();
        check_field("found", 32'(oldest.found), 32'(found_o));
        check_field("best_n", 32'(oldest.best_n), 32'(best_n_o));
        check_field("best_k", 32'(oldest.best_k), 32'(best_k_o));
        check_field("n_code", 32'(oldest.n_code), 32'(n_code_o));
        check_field("k_code", 32'(oldest.k_code), 32'(k_code_o));
        check_field("achieved_rate", oldest.rate, achieved_rate_o);
        result_count++;
        if (oldest.found) found_count++;
      end
    end
  end

  task automatic test_reset_defaults();
    request_search('0, '0);
    request_search('0, '1);
    request_search(32'd1, '0);
    request_search(32'd1, 32'd1);
    request_search(32'd1, 32'd128);
    request_search(32'd6, 32'd24);
    request_search('1, '1);
    request_search(32'h8000_0000, '1);
    wait_all_results();
  endtask

  task automatic test_range_limits();
    pnk_pkg::cfg_t c;
    c = RESET_CFG;
    c.min_n = 6'd10;
    c.max_n = 6'd5;
    load_config(c);
    request_search(32'd3, 32'd100);
    wait_all_results();
    c = RESET_CFG;
    c.min_k = 3'd3;
    c.max_k = 3'd2;
    load_config(c);
    request_search(32'd1, 32'd50);
    wait_all_results();
    // zero minima count as one, oversized maxima clip to the field size
    c = '{min_n: 6'd0, max_n: 6'd63, min_k: 3'd0, max_k: 3'd7, post_div_en: 1'b0,
          post_div: 8'd1, n_offset: 1'b1, k_offset: 1'b1};
    load_config(c);
    request_search('0, 32'd5);
    request_search(32'd1, '1);
    request_search(32'd7, 32'd1000);
    wait_all_results();
  endtask

  task automatic test_post_divider();
    pnk_pkg::cfg_t c;
    c = RESET_CFG;
    c.post_div_en = 1'b1;
    c.post_div = 8'd0;
    load_config(c);
    request_search(32'd1000, 32'd20000);
    wait_all_results();
    c.post_div = 8'd255;
    load_config(c);
    request_search(32'd100, 32'd50);
    request_search(32'd3, 32'd7);
    request_search('1, '1);
    wait_all_results();
  endtask

  task automatic test_code_wrap();
    pnk_pkg::cfg_t c;
    c = RESET_CFG;
    c.n_offset = 1'b0;
    c.k_offset = 1'b0;
    load_config(c);
    request_search(32'd1, 32'd128);
    request_search(32'd5, 32'd5);
    wait_all_results();
  endtask

  task automatic test_random_sweep();
    pnk_pkg::cfg_t  c;
    pnk_pkg::rate_t parent;
    pnk_pkg::rate_t target;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       c = RESET_CFG;
        1:       c = '{min_n: 6'd0, max_n: 6'd63, min_k: 3'd0, max_k: 3'd7, post_div_en: 1'b1,
                       post_div: 8'd255, n_offset: 1'b0, k_offset: 1'b0};
        2:       c = '{min_n: 6'd32, max_n: 6'd32, min_k: 3'd4, max_k: 3'd4, post_div_en: 1'b1,
                       post_div: 8'd0, n_offset: 1'b1, k_offset: 1'b0};
        default: c = random_cfg();
      endcase
      // results cannot be held off, so the receiver-stall slot runs back to back
      case (ph % 4)
        1:       idle_pct = 86;
        3:       idle_pct = 8;
        default: idle_pct = 0;
      endcase
      load_config(c);
      repeat (125) begin
        pick_rates(parent, target);
        request_search(parent, target);
      end
      wait_all_results();
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[pll_nk_factor_search_core] ERROR");
    $finish;
  end

  initial begin
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    parent_rate_i <= '0;
    target_rate_i <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    errors = 0;
    item_count = 0;
    result_count = 0;
    found_count = 0;
    config_count = 0;
    idle_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_range_limits();
    test_post_divider();
    test_code_wrap();
    test_random_sweep();

    $display("Searched %0d rate requests under %0d register settings;", item_count, config_count);
    $display("%0d results checked, %0d of them with a fitting N/K pair.", result_count, found_count);
    if (errors == 0) begin
      $display("[pll_nk_factor_search_core] OK");
    end else begin
      $display("[pll_nk_factor_search_core] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/pnk_pkg.sv
hdl/pnk_search.sv
hdl/pnk_div.sv
hdl/pll_nk_factor_search_core.sv
verif/testbench.sv
